// ----- hdl/nearest_segment_to_point_search_macros.svh -----
// assertion macros used by the nearest segment search rtl
`ifndef NEAREST_SEGMENT_TO_POINT_SEARCH_MACROS_SVH
`define NEAREST_SEGMENT_TO_POINT_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NSPS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NSPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nsps_pkg.sv -----
// types and constants of the nearest segment search
package nsps_pkg;

    // field widths
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 4;
    localparam int PT_W       = COORD_BITS + FRAC_BITS;   // scaled point, query, reach
    localparam int KIND_W     = 2;
    localparam int IDX_OUT_W  = 16;

    // arithmetic widths
    localparam int OP_W   = PT_W + 2;           // multiplier operand
    localparam int PROD_W = 2 * OP_W;
    localparam int DIST_W = 2 * (PT_W + 1);     // squared distance
    localparam int HALF_W = DIST_W / 2;         // split of the cross magnitude
    localparam int ACC_W  = 2 * DIST_W;         // accumulator, holds cross squared
    localparam int BOX_W  = PT_W + 2;
    localparam int DIV_CNT_W = $clog2(DIST_W);

    // stream packing
    localparam int IN_RAW_W   = 4 * COORD_BITS + 3 * PT_W;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = IDX_OUT_W + DIST_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // accumulator shift codes
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_MID  = 2'd1;
    localparam logic [1:0] SH_TOP  = 2'd2;

    typedef logic signed [PT_W-1:0] t_point;
    typedef logic signed [OP_W-1:0] t_operand;
    typedef logic [DIST_W-1:0]      t_dist;

endpackage

// ----- hdl/nearest_segment_to_point_search.sv -----
// nearest segment search: sequencer around one shared multiply-accumulate and divide step
//
// usage
//   slave stream carries one item per transfer: tuser is the kind (begin, segment,
//   end), tdata holds the segment endpoints, query point and reach. begin loads the
//   query point and reach and starts the best distance at reach squared. segment
//   items are numbered from 0 and tested. end emits one transfer on the master
//   stream: tuser is the found flag, tdata holds index and squared distance.
//   an unused kind is taken and dropped.
// datapath and flow
//   all products go through one 22x22 signed multiplier feeding an 84-bit
//   accumulator; the in-band case then runs a restoring divider, one quotient bit
//   per cycle. a segment holds the block through the box test alone when it fails,
//   through an endpoint distance, or on through the divider. begin holds it while
//   reach squared is formed; end loads the output register directly from idle.
//   s_axis_tready is high only while the sequencer is idle.
// reset and stalls
//   synchronous active-low reset clears the query state, found flag, segment count
//   and the output valid; segments before any begin search the origin, zero reach.
//   a result held in the output register blocks every input until it is taken.
`include "nearest_segment_to_point_search_macros.svh"

module nearest_segment_to_point_search
    import nsps_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x, start_y, end_x, end_y, query_x, query_y, reach, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // nearest_index, nearest_dist_sqr, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // found
    output logic                  m_axis_tuser
);

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_REACH = 5'd1;
    localparam logic [4:0] ST_BOX   = 5'd2;
    localparam logic [4:0] ST_LEN0  = 5'd3;
    localparam logic [4:0] ST_LEN1  = 5'd4;
    localparam logic [4:0] ST_DOT0  = 5'd5;
    localparam logic [4:0] ST_DOT1  = 5'd6;
    localparam logic [4:0] ST_PICK  = 5'd7;
    localparam logic [4:0] ST_ES0   = 5'd8;
    localparam logic [4:0] ST_ES1   = 5'd9;
    localparam logic [4:0] ST_EE0   = 5'd10;
    localparam logic [4:0] ST_EE1   = 5'd11;
    localparam logic [4:0] ST_CR0   = 5'd12;
    localparam logic [4:0] ST_CR1   = 5'd13;
    localparam logic [4:0] ST_MAG   = 5'd14;
    localparam logic [4:0] ST_SQ0   = 5'd15;
    localparam logic [4:0] ST_SQ1   = 5'd16;
    localparam logic [4:0] ST_SQ2   = 5'd17;
    localparam logic [4:0] ST_DIVI  = 5'd18;
    localparam logic [4:0] ST_DIV   = 5'd19;
    localparam logic [4:0] ST_CMP   = 5'd20;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIST_W - 1);

    logic [4:0]            r_state, n_state;

    // query state
    t_point                r_px, r_py;
    logic [PT_W-1:0]       r_reach;
    t_dist                 r_best;
    logic [INDEX_BITS-1:0] r_best_index;
    logic                  r_found;
    logic [INDEX_BITS-1:0] r_count;

    // current segment, scaled to sixteenths
    t_point                r_sx, r_sy, r_ex, r_ey;
    logic [INDEX_BITS-1:0] r_idx;

    // datapath registers
    logic signed [ACC_W-1:0] r_acc, n_acc;
    t_dist                   r_len;
    t_dist                   r_mag;
    t_dist                   r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;

    // output register
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_OUT_W-1:0]  r_out_index;
    t_dist                 r_out_dist;

    logic in_xfer;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // differences feeding the multiplier
    t_operand dx, dy, wx, wy, vx, vy, mh, ml, reach_op;
    assign dx = OP_W'(r_ex) - OP_W'(r_sx);
    assign dy = OP_W'(r_ey) - OP_W'(r_sy);
    assign wx = OP_W'(r_px) - OP_W'(r_sx);
    assign wy = OP_W'(r_py) - OP_W'(r_sy);
    assign vx = OP_W'(r_ex) - OP_W'(r_px);
    assign vy = OP_W'(r_ey) - OP_W'(r_py);
    assign mh = $signed(OP_W'(r_mag[DIST_W-1:HALF_W]));
    assign ml = $signed(OP_W'(r_mag[HALF_W-1:0]));
    assign reach_op = $signed(OP_W'(r_reach));

    // shared multiply-accumulate
    t_operand                mul_a, mul_b;
    logic [1:0]              acc_sh;
    logic                    acc_clr;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, prod_sh, acc_base;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        acc_sh  = SH_NONE;
        acc_clr = 1'b0;
        case (r_state)
            ST_REACH: begin mul_a = reach_op; mul_b = reach_op; acc_clr = 1'b1; end
            ST_LEN0:  begin mul_a = dx; mul_b = dx; acc_clr = 1'b1; end
            ST_LEN1:  begin mul_a = dy; mul_b = dy; end
            ST_DOT0:  begin mul_a = wx; mul_b = dx; acc_clr = 1'b1; end
            ST_DOT1:  begin mul_a = wy; mul_b = dy; end
            ST_ES0:   begin mul_a = wx; mul_b = wx; acc_clr = 1'b1; end
            ST_ES1:   begin mul_a = wy; mul_b = wy; end
            ST_EE0:   begin mul_a = vx; mul_b = vx; acc_clr = 1'b1; end
            ST_EE1:   begin mul_a = vy; mul_b = vy; end
            ST_CR0:   begin mul_a = wx; mul_b = dy; acc_clr = 1'b1; end
            ST_CR1:   begin mul_a = wy; mul_b = dx; end
            ST_SQ0:   begin mul_a = ml; mul_b = ml; acc_clr = 1'b1; end
            // cross term counted twice: shift one further
            ST_SQ1:   begin mul_a = mh; mul_b = ml; acc_sh = SH_MID; end
            ST_SQ2:   begin mul_a = mh; mul_b = mh; acc_sh = SH_TOP; end
            default: ;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = ACC_W'(prod);
    assign acc_base = acc_clr ? '0 : r_acc;

    always_comb begin
        case (acc_sh)
            SH_MID:  prod_sh = prod_ext <<< (HALF_W + 1);
            SH_TOP:  prod_sh = prod_ext <<< DIST_W;
            default: prod_sh = prod_ext;
        endcase
    end

    // restoring divide step: next quotient bit from the top of the numerator
    logic [DIST_W+1:0] div_diff;
    logic              div_take;
    assign div_diff = {1'b0, r_rem, r_acc[DIST_W-1]} - {2'b00, r_len};
    assign div_take = !div_diff[DIST_W+1];

    // box test widened by reach, inclusive
    logic signed [BOX_W-1:0] reach_s, px_s, py_s, lo_x, hi_x, lo_y, hi_y;
    logic                    box_hit;
    assign reach_s = $signed(BOX_W'(r_reach));
    assign px_s    = BOX_W'(r_px);
    assign py_s    = BOX_W'(r_py);
    assign lo_x    = BOX_W'((r_sx < r_ex) ? r_sx : r_ex) - reach_s;
    assign hi_x    = BOX_W'((r_sx < r_ex) ? r_ex : r_sx) + reach_s;
    assign lo_y    = BOX_W'((r_sy < r_ey) ? r_sy : r_ey) - reach_s;
    assign hi_y    = BOX_W'((r_sy < r_ey) ? r_ey : r_sy) + reach_s;
    assign box_hit = (px_s >= lo_x) && (px_s <= hi_x) && (py_s >= lo_y) && (py_s <= hi_y);

    // projection checks on the dot product held in the accumulator
    logic dot_neg, dot_past;
    assign dot_neg  = r_acc[ACC_W-1];
    assign dot_past = r_acc[DIST_W:0] > {1'b0, r_len};

    logic cmp_take;
    assign cmp_take = r_acc[DIST_W-1:0] <= r_best;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && s_axis_tuser == KIND_BEGIN) begin
                    n_state = ST_REACH;
                end else if (in_xfer && s_axis_tuser == KIND_SEGMENT) begin
                    n_state = ST_BOX;
                end
            end
            ST_REACH: n_state = ST_IDLE;
            ST_BOX:   n_state = box_hit ? ST_LEN0 : ST_IDLE;
            ST_LEN0, ST_LEN1, ST_DOT0, ST_ES0, ST_EE0, ST_CR0, ST_SQ0, ST_SQ1: begin
                n_acc   = acc_base + prod_sh;
                n_state = r_state + 5'd1;
            end
            ST_DOT1: begin
                n_acc   = acc_base + prod_sh;
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (r_len == '0 || dot_neg) begin
                    n_state = ST_ES0;
                end else if (dot_past) begin
                    n_state = ST_EE0;
                end else begin
                    n_state = ST_CR0;
                end
            end
            ST_ES1, ST_EE1: begin
                n_acc   = acc_base + prod_sh;
                n_state = ST_CMP;
            end
            ST_CR1: begin
                n_acc   = acc_base - prod_sh;
                n_state = ST_MAG;
            end
            ST_MAG: n_state = ST_SQ0;
            ST_SQ2: begin
                n_acc   = acc_base + prod_sh;
                n_state = ST_DIVI;
            end
            ST_DIVI: n_state = ST_DIV;
            ST_DIV: begin
                n_acc[DIST_W-1:0] = {r_acc[DIST_W-2:0], div_take};
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control and query state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_px         <= '0;
            r_py         <= '0;
            r_reach      <= '0;
            r_best       <= '0;
            r_best_index <= '0;
            r_found      <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer && s_axis_tuser == KIND_BEGIN) begin
                r_px         <= s_axis_tdata[4*COORD_BITS +: PT_W];
                r_py         <= s_axis_tdata[4*COORD_BITS+PT_W +: PT_W];
                r_reach      <= s_axis_tdata[4*COORD_BITS+2*PT_W +: PT_W];
                r_best_index <= '0;
                r_found      <= 1'b0;
                r_count      <= '0;
            end
            if (in_xfer && s_axis_tuser == KIND_SEGMENT) begin
                r_count <= r_count + INDEX_BITS'(1);
            end
            if (r_state == ST_REACH) begin
                r_best <= prod[DIST_W-1:0];
            end
            // later segments win ties
            if (r_state == ST_CMP && cmp_take) begin
                r_best       <= r_acc[DIST_W-1:0];
                r_best_index <= r_idx;
                r_found      <= 1'b1;
            end
            if (in_xfer && s_axis_tuser == KIND_END) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tuser == KIND_SEGMENT) begin
            r_sx  <= {s_axis_tdata[0*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
            r_sy  <= {s_axis_tdata[1*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
            r_ex  <= {s_axis_tdata[2*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
            r_ey  <= {s_axis_tdata[3*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
            r_idx <= r_count;
        end
        if (in_xfer && s_axis_tuser == KIND_END) begin
            r_out_found <= r_found;
            r_out_index <= IDX_OUT_W'(r_best_index);
            r_out_dist  <= r_best;
        end
        r_acc <= n_acc;
        // length squared is still in the accumulator when the dot product starts
        if (r_state == ST_DOT0) begin
            r_len <= r_acc[DIST_W-1:0];
        end
        if (r_state == ST_MAG) begin
            r_mag <= r_acc[ACC_W-1] ? DIST_W'(-r_acc) : r_acc[DIST_W-1:0];
        end
        // quotient fits in DIST_W bits, so the upper numerator part starts below len
        if (r_state == ST_DIVI) begin
            r_rem <= DIST_W'(r_acc[ACC_W-2:DIST_W]);
            r_cnt <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= div_take ? div_diff[DIST_W-1:0] : {r_rem[DIST_W-2:0], r_acc[DIST_W-1]};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_dist, r_out_index};

    `NSPS_ASSERT_NOW(a_ready_only_idle, i_clk, i_rst_n, s_axis_tready, r_state == ST_IDLE, "ready outside idle")
    `NSPS_ASSERT_NOW(a_div_count_range, i_clk, i_rst_n, r_state == ST_DIV, r_cnt <= DIV_LAST, "divider overran")
    `NSPS_ASSERT_NEXT(a_take_sets_found, i_clk, i_rst_n, r_state == ST_CMP && cmp_take, r_found && r_best_index == $past(r_idx), "best not updated")
    `NSPS_ASSERT_NOW(a_none_index_zero, i_clk, i_rst_n, !r_found, r_best_index == '0, "index set without a find")

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the nearest segment search block
`timescale 1ns / 100ps

module testbench
    import nsps_pkg::*;
();

    localparam int INDEX_BITS   = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 80;     // covers the longest segment path, through the divider
    localparam int HOLD_CYCLES  = 3000;

    // kind code that the block takes and drops
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam t_dist DIST_MAX = '1;

    // one report of the end item
    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
        t_dist                dsq;
    } t_search_report;

    // tracks the search state and holds the reports still to come
    class nearest_report_board;
        t_point               query_x;
        t_point               query_y;
        logic [PT_W-1:0]      reach;
        t_dist                best_dsq;
        logic [INDEX_BITS-1:0] best_index;
        logic                 hit;
        logic [INDEX_BITS-1:0] seg_count;
        t_search_report       reports_due[$];
        int fail_count;
        int queries;
        int segments;
        int in_box;
        int reports;

        function new();
            query_x    = '0;
            query_y    = '0;
            reach      = '0;
            best_dsq   = '0;
            best_index = '0;
            hit        = 1'b0;
            seg_count  = '0;
            fail_count = 0;
            queries    = 0;
            segments   = 0;
            in_box     = 0;
            reports    = 0;
        endfunction

        // squared distance of a point to a segment, floored, coordinates in 1/16 units
        function t_dist point_segment_dsq(longint sx, longint sy, longint ex, longint ey,
                                          longint px, longint py);
            longint dx, dy, wx, wy, len, dot, crs;
            logic [63:0]  mag;
            logic [127:0] num;
            logic [127:0] lw;
            dx  = ex - sx;
            dy  = ey - sy;
            wx  = px - sx;
            wy  = py - sy;
            len = dx * dx + dy * dy;
            dot = wx * dx + wy * dy;
            if (len == 0 || dot < 0) begin
                num = 128'((sx - px) * (sx - px) + (sy - py) * (sy - py));
            end else if (dot > len) begin
                num = 128'((ex - px) * (ex - px) + (ey - py) * (ey - py));
            end else begin
                // perpendicular case: floor(cross^2 / len), len being the squared length
                crs = wx * dy - wy * dx;
                mag = (crs < 0) ? 64'(-crs) : 64'(crs);
                lw  = 128'(len);
                num = 128'(mag);
                num = (num * num) / lw;
            end
            return (num > 128'(DIST_MAX)) ? DIST_MAX : t_dist'(num);
        endfunction

        // advance the search state for one accepted input transfer
        function void note_item(logic [KIND_W-1:0] kind,
                                logic signed [COORD_BITS-1:0] sx_in,
                                logic signed [COORD_BITS-1:0] sy_in,
                                logic signed [COORD_BITS-1:0] ex_in,
                                logic signed [COORD_BITS-1:0] ey_in,
                                t_point qx_in, t_point qy_in, logic [PT_W-1:0] reach_in);
            longint sx, sy, ex, ey, px, py, r;
            t_dist dsq;
            logic [INDEX_BITS-1:0] idx;
            t_search_report rep;
            case (kind)
                KIND_BEGIN: begin
                    query_x    = qx_in;
                    query_y    = qy_in;
                    reach      = reach_in;
                    best_dsq   = t_dist'(longint'(reach_in) * longint'(reach_in));
                    best_index = '0;
                    hit        = 1'b0;
                    seg_count  = '0;
                    queries++;
                end
                KIND_SEGMENT: begin
                    sx  = longint'(sx_in) <<< FRAC_BITS;
                    sy  = longint'(sy_in) <<< FRAC_BITS;
                    ex  = longint'(ex_in) <<< FRAC_BITS;
                    ey  = longint'(ey_in) <<< FRAC_BITS;
                    px  = longint'(query_x);
                    py  = longint'(query_y);
                    r   = longint'(reach);
                    idx = seg_count;
                    seg_count++;
                    segments++;
                    // bounding box widened by the reach, edges included
                    if (px >= ((sx < ex) ? sx : ex) - r && px <= ((sx < ex) ? ex : sx) + r &&
                        py >= ((sy < ey) ? sy : ey) - r && py <= ((sy < ey) ? ey : sy) + r) begin
                        in_box++;
                        dsq = point_segment_dsq(sx, sy, ex, ey, px, py);
                        // ties go to the later segment
                        if (dsq <= best_dsq) begin
                            best_dsq   = dsq;
                            best_index = idx;
                            hit        = 1'b1;
                        end
                    end
                end
                KIND_END: begin
                    rep.found = hit;
                    rep.index = hit ? IDX_OUT_W'(best_index) : '0;
                    rep.dsq   = best_dsq;
                    reports_due.push_back(rep);
                end
                default: ;
            endcase
        endfunction

        // compare one output transfer with the oldest report due
        function void check_report(logic found, logic [IDX_OUT_W-1:0] index, t_dist dsq);
            t_search_report want;
            reports++;
            if (reports_due.size() == 0) begin
                $error("unexpected report: found %0d index %0d dist_sqr %0d", found, index, dsq);
                fail_count++;
                return;
            end
            want = reports_due.pop_front();
            if (want.found !== found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                fail_count++;
            end
            if (want.index !== index) begin
                $error("nearest_index: expected %0d, got %0d", want.index, index);
                fail_count++;
            end
            if (want.dsq !== dsq) begin
                $error("nearest_dist_sqr: expected %0d, got %0d", want.dsq, dsq);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // start_x, start_y, end_x, end_y, query_x, query_y, reach, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // kind
    logic [KIND_W-1:0]     s_axis_tuser  = KIND_BEGIN;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // nearest_index, nearest_dist_sqr, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // found
    logic                  m_axis_tuser;

    nearest_report_board board;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int rx_hold_left       = 0;   // long hold-off, counted down by the receiver
    int items_sent         = 0;   // accepted transfers that the block acts on
    int cycle_count        = 0;

    nearest_segment_to_point_search #(
        .INDEX_BITS(INDEX_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("nearest_segment_to_point_search: mismatch");
        $finish;
    end

    // master side: check each transfer, then pick tready for the next edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                board.check_report(m_axis_tuser, m_axis_tdata[IDX_OUT_W-1:0],
                                   m_axis_tdata[IDX_OUT_W +: DIST_W]);
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clip_to(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // offer one item, with random idle cycles ahead of it, until it is taken;
    // tvalid stays high into the next item when no idle cycle is drawn
    task automatic send_item(logic [KIND_W-1:0] kind,
                             logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                             logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey,
                             logic [PT_W-1:0] qx, logic [PT_W-1:0] qy,
                             logic [PT_W-1:0] reach);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_DATA_W - IN_RAW_W){1'b0}}, reach, qy, qx, ey, ex, sy, sx};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(kind, sx, sy, ex, ey, qx, qy, reach);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    // fields a kind does not use carry random bits
    task automatic send_begin(int qx, int qy, int reach);
        send_item(KIND_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  20'(qx), 20'(qy), 20'(reach));
    endtask

    task automatic send_segment(int sx, int sy, int ex, int ey);
        send_item(KIND_SEGMENT, 16'(sx), 16'(sy), 16'(ex), 16'(ey),
                  20'($urandom), 20'($urandom), 20'($urandom));
    endtask

    task automatic send_end();
        send_item(KIND_END, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  20'($urandom), 20'($urandom), 20'($urandom));
    endtask

    // random kinds with random fields, kind 3 included
    task automatic run_noise();
        int n;
        n = rand_in(1, 4);
        repeat (n) begin
            send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
        end
    endtask

    // well-formed query: begin, segments mostly clustered around the point, end
    task automatic run_query();
        int span, cx, cy, qx, qy, r, n, roll;
        int sx, sy, ex, ey;
        case ($urandom_range(3))
            0: span = 2;
            1: span = 20;
            2: span = 400;
            default: span = 6000;
        endcase
        cx = rand_in(-32768 + span, 32767 - span);
        cy = rand_in(-32768 + span, 32767 - span);
        qx = clip_to(cx * 16 + rand_in(-span * 16, span * 16), -524288, 524287);
        qy = clip_to(cy * 16 + rand_in(-span * 16, span * 16), -524288, 524287);
        case ($urandom_range(9))
            0: r = 0;
            1: r = 1048575;
            2: r = int'($urandom_range(1048575));
            default: r = int'($urandom_range(span * 24));
        endcase
        send_begin(qx, qy, r);
        n  = rand_in(1, 12);
        sx = cx;
        sy = cy;
        ex = cx;
        ey = cy;
        for (int i = 0; i < n; i++) begin
            roll = int'($urandom_range(99));
            if (roll < 8 && i > 0) begin
                // same segment again, so the later one wins the tie
            end else if (roll < 18) begin
                sx = clip_to(cx + rand_in(-span, span), -32768, 32767);
                sy = clip_to(cy + rand_in(-span, span), -32768, 32767);
                ex = sx;
                ey = sy;
            end else if (roll < 23) begin
                sx = int'($urandom_range(65535)) - 32768;
                sy = int'($urandom_range(65535)) - 32768;
                ex = int'($urandom_range(65535)) - 32768;
                ey = int'($urandom_range(65535)) - 32768;
            end else begin
                sx = clip_to(cx + rand_in(-span, span), -32768, 32767);
                sy = clip_to(cy + rand_in(-span, span), -32768, 32767);
                ex = clip_to(cx + rand_in(-span, span), -32768, 32767);
                ey = clip_to(cy + rand_in(-span, span), -32768, 32767);
            end
            send_segment(sx, sy, ex, ey);
            if (roll < 3) send_item(KIND_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
        end
        send_end();
        if ($urandom_range(9) == 0) send_end();
    endtask

    initial begin
        int target;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        // segments before any begin search around the origin with zero reach
        send_segment(0, 0, 0, 0);
        send_segment(5, 5, 6, 6);
        send_end();
        send_end();                     // repeated end reports the same outcome
        send_item(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  20'hfffff, 20'hfffff, 20'hfffff);
        // box edge touched exactly, distance equal to reach squared both times
        send_begin(0, 0, 16);
        send_segment(1, 0, 2, 0);
        send_segment(-1, 1, 1, 1);
        send_segment(2, 2, 2, 2);
        send_end();
        // projection before the start and past the end of the segment
        send_begin(0, 0, 1000);
        send_segment(1, 0, 5, 0);
        send_segment(-5, 0, -1, 0);
        send_end();
        // extremes of point, reach and coordinates
        send_begin(-524288, 524287, 1048575);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(32767, 32767, 32767, 32767);
        send_end();
        send_begin(524287, -524288, 15);
        send_segment(32767, -32768, 32767, -32768);
        send_end();
        // begin right after begin, then an empty query
        send_begin(8, 8, 3);
        send_begin(8, 8, 1048575);
        send_end();

        // random part over the idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            target = items_sent + 390;
            while (items_sent < target) begin
                if ($urandom_range(99) < 85) run_query();
                else run_noise();
            end
        end

        // long hold-off on the master side while reports pile up behind it
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rx_hold_left       = HOLD_CYCLES;
        repeat (8) begin
            send_begin(rand_in(-64, 64), rand_in(-64, 64), rand_in(0, 200));
            send_segment(rand_in(-4, 4), rand_in(-4, 4), rand_in(-4, 4), rand_in(-4, 4));
            send_end();
            send_end();
        end
        s_axis_tvalid <= 1'b0;

        while (board.reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d queries and %0d segments (%0d inside the widened box)",
                 board.queries, board.segments, board.in_box);
        $display("%0d reports checked across idle, stall and hold-off phases",
                 board.reports);
        if (board.fail_count == 0 && board.reports_due.size() == 0) begin
            $display("nearest_segment_to_point_search: match");
        end else begin
            $display("nearest_segment_to_point_search: mismatch");
        end
        $finish;
    end

endmodule
